@@ hw/rtl/nte_pkg.sv @@
// Shared types, constants and helpers for the number-to-English word token block.
// Depends on nothing; every other file in hw/rtl imports it.
`default_nettype none

package nte_pkg;

   localparam int NUM_W          = 31;
   localparam int WORD_W         = 5;
   localparam int BCD_DIGITS     = 10;
   localparam int ENT_DIGITS     = 12;
   localparam int GROUPS         = 4;
   localparam int STEPS          = 5;
   localparam int POS_N          = GROUPS * STEPS;
   localparam int POS_W          = $clog2(POS_N);
   localparam int CONV_BITS      = 32;
   localparam int BITS_PER_CYCLE = 2;
   localparam int CONV_CYCLES    = CONV_BITS / BITS_PER_CYCLE;
   localparam int CNT_W          = $clog2(CONV_CYCLES);
   localparam int QUEUE_DEPTH    = 2;

   // slot order inside one three-digit group
   localparam int STEP_DIGIT   = 0;
   localparam int STEP_HUNDRED = 1;
   localparam int STEP_TENS    = 2;
   localparam int STEP_ONES    = 3;
   localparam int STEP_SCALE   = 4;

   localparam logic [WORD_W-1:0] TOK_ZERO     = 5'd0;
   localparam logic [WORD_W-1:0] TOK_TEEN_OFS = 5'd10;
   localparam logic [WORD_W-1:0] TOK_TENS_OFS = 5'd18;
   localparam logic [WORD_W-1:0] TOK_HUNDRED  = 5'd28;
   localparam logic [WORD_W-1:0] TOK_THOUSAND = 5'd29;

   // one classified number: decimal digits, slots that emit, zero flag
   typedef struct packed {
      logic [ENT_DIGITS*4-1:0] digits;
      logic [POS_N-1:0]        mask;
      logic                    zero;
   } entry_type;

   function automatic logic [3:0] digit_at(input logic [ENT_DIGITS*4-1:0] d, input int i);
      return d[4*i +: 4];
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/nte_front.sv @@
// Front end: takes a number, converts it to BCD two bits a cycle and classifies
// which token slots emit. Depends on nte_pkg.
`default_nettype none

module nte_front
   import nte_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [NUM_W-1:0]  req_number,
   output logic                   q_push,
   output entry_type              q_entry,
   input  wire logic              q_full
);

   typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_PUSH} state_type;

   state_type                  state_ff, state_in;
   logic [CONV_BITS-1:0]       bin_ff, bin_in;
   logic [BCD_DIGITS*4-1:0]    bcd_ff, bcd_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       zero_ff, zero_in;
   logic [ENT_DIGITS*4-1:0]    digits;

   function automatic logic [BCD_DIGITS*4-1:0] dabble(input logic [BCD_DIGITS*4-1:0] b,
                                                      input logic din);
      logic [BCD_DIGITS*4-1:0] a;
      a = b;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (a[4*i +: 4] >= 4'd5) begin
            a[4*i +: 4] = a[4*i +: 4] + 4'd3;
         end
      end
      return {a[BCD_DIGITS*4-2:0], din};
   endfunction

   function automatic logic [POS_N-1:0] build_mask(input logic [ENT_DIGITS*4-1:0] d,
                                                   input logic zero);
      logic [POS_N-1:0] m;
      logic [3:0]       h, t, o;
      int               base;
      m = '0;
      for (int g = 0; g < GROUPS; g++) begin
         h    = digit_at(d, 3*g + 2);
         t    = digit_at(d, 3*g + 1);
         o    = digit_at(d, 3*g);
         base = (GROUPS - 1 - g) * STEPS;
         m[base + STEP_DIGIT]   = (h != 4'd0);
         m[base + STEP_HUNDRED] = (h != 4'd0);
         m[base + STEP_TENS]    = (t >= 4'd2);
         m[base + STEP_ONES]    = (t == 4'd1) || (o != 4'd0);
         m[base + STEP_SCALE]   = (g > 0) && ((h | t | o) != 4'd0);
      end
      if (zero) begin
         m = POS_N'(1);
      end
      return m;
   endfunction

   assign digits          = {{((ENT_DIGITS - BCD_DIGITS) * 4){1'b0}}, bcd_ff};
   assign q_entry.digits  = digits;
   assign q_entry.mask    = build_mask(digits, zero_ff);
   assign q_entry.zero    = zero_ff;
   assign req_stall       = (state_ff != ST_IDLE);
   assign q_push          = (state_ff == ST_PUSH) && !q_full;

   always_comb begin
      logic [BCD_DIGITS*4-1:0] b;
      state_in = state_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      cnt_in   = cnt_ff;
      zero_in  = zero_ff;
      b        = bcd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               bin_in   = CONV_BITS'(req_number);
               bcd_in   = '0;
               cnt_in   = '0;
               zero_in  = (req_number == '0);
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            for (int k = 0; k < BITS_PER_CYCLE; k++) begin
               b = dabble(b, bin_ff[CONV_BITS-1-k]);
            end
            bcd_in = b;
            bin_in = {bin_ff[CONV_BITS-BITS_PER_CYCLE-1:0], {BITS_PER_CYCLE{1'b0}}};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CONV_CYCLES - 1)) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (!q_full) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      cnt_ff  <= cnt_in;
      zero_ff <= zero_in;
   end

endmodule

`default_nettype wire

@@ hw/rtl/nte_queue.sv @@
// Short queue of classified numbers between the front and back ends.
// Depends on nte_pkg for the entry type.
`default_nettype none

module nte_queue
   import nte_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
)
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type wr_data,
   input  wire logic      pop,
   output entry_type      rd_data,
   output logic           full,
   output logic           empty
);

   localparam int PTR_W = $clog2(Depth);
   localparam int CNT_W = $clog2(Depth + 1);

   entry_type         mem_ff [Depth];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;

   assign full    = (count_ff == CNT_W'(Depth));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/nte_back.sv @@
// Back end: walks the emitting slots of one number and drives one token per
// cycle while rsp_stall is low, through a registered output. Depends on nte_pkg.
`default_nettype none

module nte_back
   import nte_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire entry_type          q_data,
   input  wire logic               q_empty,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [WORD_W-1:0]       rsp_word,
   output logic                    rsp_last
);

   entry_type          ent_ff;
   logic               busy_ff;
   logic               rsp_valid_ff;
   logic [WORD_W-1:0]  rsp_word_ff;
   logic               rsp_last_ff;
   logic               out_free;
   logic [POS_W-1:0]   pos;
   logic [POS_N-1:0]   mask_in;
   logic [WORD_W-1:0]  tok [POS_N];
   logic [WORD_W-1:0]  word_in;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign q_pop     = !busy_ff && !q_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign rsp_last  = rsp_last_ff;

   // token that each slot would give
   always_comb begin
      logic [3:0] h, t, o;
      int         base;
      for (int g = 0; g < GROUPS; g++) begin
         h    = digit_at(ent_ff.digits, 3*g + 2);
         t    = digit_at(ent_ff.digits, 3*g + 1);
         o    = digit_at(ent_ff.digits, 3*g);
         base = (GROUPS - 1 - g) * STEPS;
         tok[base + STEP_DIGIT]   = WORD_W'(h);
         tok[base + STEP_HUNDRED] = TOK_HUNDRED;
         tok[base + STEP_TENS]    = TOK_TENS_OFS + WORD_W'(t);
         tok[base + STEP_ONES]    = (t == 4'd1) ? TOK_TEEN_OFS + WORD_W'(o) : WORD_W'(o);
         tok[base + STEP_SCALE]   = (g == 0) ? TOK_THOUSAND
                                             : TOK_THOUSAND + WORD_W'(g - 1);
      end
   end

   // first pending slot, most significant first
   always_comb begin
      pos = '0;
      for (int i = POS_N - 1; i >= 0; i--) begin
         if (ent_ff.mask[i]) begin
            pos = POS_W'(i);
         end
      end
   end

   assign mask_in = ent_ff.mask & ~(POS_N'(1) << pos);
   assign word_in = ent_ff.zero ? TOK_ZERO : tok[pos];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && out_free && (mask_in == '0)) begin
            busy_ff <= 1'b0;
         end
         if (out_free) begin
            rsp_valid_ff <= busy_ff;
         end
      end
      if (q_pop) begin
         ent_ff <= q_data;
      end else if (busy_ff && out_free) begin
         ent_ff.mask <= mask_in;
      end
      if (busy_ff && out_free) begin
         rsp_word_ff <= word_in;
         rsp_last_ff <= (mask_in == '0);
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/number_to_english_word_tokens.sv @@
// Top level of the number-to-English word token block.
// Depends on nte_pkg, nte_front, nte_queue and nte_back.
//
// Usage:
//   req channel: req_number (31 bits) with req_valid/req_stall. A transaction
//   is taken at a rising edge with req_valid high and req_stall low.
//   rsp channel: rsp_word (token code) and rsp_last with rsp_valid/rsp_stall.
//   Each number yields one to sixteen token transactions, most significant
//   part first; rsp_last marks the final token of a number.
// Operation:
//   The front end turns the number into BCD two bits a cycle, then classifies
//   it; it holds req_stall high until the number is in the queue, so it takes
//   no new number before then. The back end loads a queued number into a
//   register and then gives one token a cycle while rsp_stall is low; it pops
//   the next number only once the last token of the current one is registered.
// Stalls: rsp_stall holds the output register; the back end waits, the queue
//   fills and the front end keeps converting until the queue is full, then
//   holds req_stall high.
// Reset: synchronous, active high; clears the front state machine, the queue
//   pointers and the output valid. No clearing pass is needed.
`default_nettype none

module number_to_english_word_tokens
   import nte_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [NUM_W-1:0]  req_number,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [WORD_W-1:0]      rsp_word,
   output logic                   rsp_last
);

   entry_type q_wr_data;
   entry_type q_rd_data;
   logic      q_push;
   logic      q_pop;
   logic      q_full;
   logic      q_empty;

   // classify numbers and hand them to the queue
   nte_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_number (req_number),
      .q_push     (q_push),
      .q_entry    (q_wr_data),
      .q_full     (q_full)
   );

   // decouple conversion from token output
   nte_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr_data),
      .pop     (q_pop),
      .rd_data (q_rd_data),
      .full    (q_full),
      .empty   (q_empty)
   );

   // emit tokens one per cycle while rsp_stall is low
   nte_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_data    (q_rd_data),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .rsp_last  (rsp_last)
   );

   // never push into a full queue
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("queue push while full");

   // never pop an empty queue
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("queue pop while empty");

   // a taken request blocks the next one while it converts
   assert property (@(posedge clock) disable iff (reset)
                    (req_valid && !req_stall) |=> req_stall)
      else $error("front end took a second request during conversion");

   // Zero only ever stands alone
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && (rsp_word == TOK_ZERO)) |-> rsp_last)
      else $error("Zero token not marked last");

endmodule

`default_nettype wire
